[rtl/rmsst_pkg.sv]
// Shared constants, operation codes and handshake structs for the running mean/stdev block.
package rmsst_pkg;

  localparam int SAMPLE_W   = 48;
  localparam int COUNT_BITS = 32;
  localparam int FRAC_BITS  = 16;
  localparam int VAR_W      = 64;
  localparam int CFG_W      = 16;

  // Divisors are the count or the count plus one.
  localparam int DIV_W      = COUNT_BITS + 1;
  localparam int MUL_B_W    = SAMPLE_W;
  localparam int PROD_W     = VAR_W + MUL_B_W;
  localparam int RAD_W      = VAR_W + FRAC_BITS;
  localparam int ROOT_W     = RAD_W / 2;
  localparam int REM_W      = ROOT_W + 4;
  localparam int MUL_STEPS  = MUL_B_W;
  localparam int DIV_STEPS  = VAR_W;
  localparam int CNT_W      = 6;

  // 3.92 in Q.16, rounded to nearest.
  localparam int STOP_W = 18;
  localparam logic [STOP_W-1:0] STOP_FACTOR = 18'd256901;
  localparam int CMP_W = SAMPLE_W + STOP_W;

  localparam logic CFG_ERROR_RATIO = 1'b0;
  localparam logic CFG_MIN_SAMPLES = 1'b1;

  typedef enum logic [1:0] {
    OP_MUL  = 2'd0,
    OP_DIV  = 2'd1,
    OP_SQRT = 2'd2
  } iter_op_t;

  typedef struct packed {
    logic             start;
    iter_op_t         op;
    logic [VAR_W-1:0] a;
    logic [VAR_W-1:0] b;
  } iter_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] x;
    logic [MUL_B_W-1:0] y;
  } iter_rsp_t;

endpackage

[rtl/rmsst_if.sv]
// Valid/ready channel interfaces for samples and results.
interface rmsst_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [rmsst_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface rmsst_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [rmsst_pkg::SAMPLE_W-1:0]   mean_out;
  logic [rmsst_pkg::SAMPLE_W-1:0]          stdev_out;
  logic [rmsst_pkg::COUNT_BITS-1:0]        sample_count;
  logic                                  done_res;

  modport source (output valid, output mean_out, output stdev_out, output sample_count,
                  output done_res, input ready);
  modport sink (input valid, input mean_out, input stdev_out, input sample_count,
                input done_res, output ready);
endinterface

[rtl/running_mean_stdev_stop_test.sv]
// Running mean and standard error of a signed Q32.16 sample stream with a precision stop test:
// one sample is taken at a time, and in_ch.ready stays low until its result has been
// transferred. The first sample goes straight to the result. Every later sample runs three
// 64-step divisions, two 48-step multiplications (one when the squared mean step saturates)
// and a 40-step square root on one shared bit-serial unit. The error ratio and minimum count
// registers are written through cfg_*.
module running_mean_stdev_stop_test (
  input  logic                         clk,
  input  logic                         rst_n,
  rmsst_in_if.sink                     in_ch,
  rmsst_out_if.source                  out_ch,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [rmsst_pkg::CFG_W-1:0]  cfg_wdata
);
  import rmsst_pkg::*;

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b000_0000_0001,
    ST_DIVM  = 11'b000_0000_0010,
    ST_MULSQ = 11'b000_0000_0100,
    ST_MULN  = 11'b000_0000_1000,
    ST_DIVV  = 11'b000_0001_0000,
    ST_DIVQ  = 11'b000_0010_0000,
    ST_SQRT  = 11'b000_0100_0000,
    ST_PROD1 = 11'b000_1000_0000,
    ST_PROD2 = 11'b001_0000_0000,
    ST_CMP   = 11'b010_0000_0000,
    ST_OUT   = 11'b100_0000_0000
  } state_t;

  state_t                 state_r, state_nxt;
  logic                   launch_r;
  logic [CFG_W-1:0]       err_ratio_r;
  logic [CFG_W-1:0]       min_samples_r;
  logic [COUNT_BITS-1:0]  count_r;
  logic [SAMPLE_W-1:0]    mean_r;
  logic [VAR_W-1:0]       var_r;

  logic [SAMPLE_W-1:0]    sample_r;
  logic [COUNT_BITS-1:0]  k_r;
  logic [SAMPLE_W-1:0]    ad_r;
  logic [VAR_W-1:0]       tmp_r;
  logic [VAR_W-1:0]       term_r;
  logic [SAMPLE_W-1:0]    stdev_r;
  logic [CMP_W-1:0]       p1_r;
  logic [CMP_W-1:0]       p2_r;
  logic                   done_r;

  iter_req_t              req;
  iter_rsp_t              rsp;

  logic                   in_xfer;
  logic [SAMPLE_W:0]      diff;
  logic [SAMPLE_W:0]      diff_mag;
  logic [DIV_W-1:0]       n_cnt;
  logic                   sq_sat;
  logic [SAMPLE_W-1:0]    mean_step;
  logic [VAR_W:0]         var_sum;
  logic [SAMPLE_W-1:0]    amean;
  logic [SAMPLE_W-1:0]    mul_a;
  logic [STOP_W-1:0]      mul_b;
  logic [CMP_W-1:0]       mul_p;

  rmsst_iter u_iter (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  always_comb begin
    in_xfer   = in_ch.valid && (state_r == ST_IDLE);
    diff      = {sample_r[SAMPLE_W-1], sample_r} - {mean_r[SAMPLE_W-1], mean_r};
    diff_mag  = diff[SAMPLE_W] ? (~diff + 1'b1) : diff;
    n_cnt     = {1'b0, k_r} + 1'b1;
    sq_sat    = |rsp.x[PROD_W-1:VAR_W+FRAC_BITS];
    // The quotient is applied on the cycle it arrives, before ad_r holds it.
    mean_step = diff[SAMPLE_W] ? (~rsp.x[SAMPLE_W-1:0] + 1'b1) : rsp.x[SAMPLE_W-1:0];
    var_sum   = {1'b0, var_r - rsp.x[VAR_W-1:0]} + {1'b0, term_r};
    amean     = mean_r[SAMPLE_W-1] ? (~mean_r + 1'b1) : mean_r;
    mul_a     = (state_r == ST_PROD1) ? stdev_r : amean;
    mul_b     = (state_r == ST_PROD1) ? STOP_FACTOR : STOP_W'(err_ratio_r);
    mul_p     = CMP_W'(mul_a * mul_b);
  end

  always_comb begin
    req.start = launch_r;
    req.op    = OP_DIV;
    req.a     = '0;
    req.b     = VAR_W'(k_r);
    case (state_r)
      ST_DIVM: begin
        req.a = VAR_W'(diff_mag);
        req.b = VAR_W'(n_cnt);
      end
      ST_MULSQ: begin
        req.op = OP_MUL;
        req.a  = VAR_W'(ad_r);
        req.b  = VAR_W'(ad_r);
      end
      ST_MULN: begin
        req.op = OP_MUL;
        req.a  = tmp_r;
        req.b  = VAR_W'(n_cnt);
      end
      ST_DIVV, ST_DIVQ: begin
        req.a = var_r;
      end
      ST_SQRT: begin
        req.op = OP_SQRT;
        req.a  = tmp_r;
      end
      default: begin
        req.start = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = (count_r == '0) ? ST_OUT : ST_DIVM;
        end
      end
      ST_DIVM:  if (rsp.done) state_nxt = ST_MULSQ;
      ST_MULSQ: if (rsp.done) state_nxt = sq_sat ? ST_DIVV : ST_MULN;
      ST_MULN:  if (rsp.done) state_nxt = ST_DIVV;
      ST_DIVV:  if (rsp.done) state_nxt = ST_DIVQ;
      ST_DIVQ:  if (rsp.done) state_nxt = ST_SQRT;
      ST_SQRT:  if (rsp.done) state_nxt = ST_PROD1;
      ST_PROD1: state_nxt = ST_PROD2;
      ST_PROD2: state_nxt = ST_CMP;
      ST_CMP:   state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_ch.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      launch_r      <= 1'b0;
      err_ratio_r   <= CFG_W'(655);
      min_samples_r <= CFG_W'(30);
      count_r       <= '0;
      mean_r        <= '0;
      var_r         <= '0;
    end else begin
      state_r  <= state_nxt;
      // The shared unit starts once, on the first cycle of each new state.
      launch_r <= (state_nxt != state_r);
      if (cfg_we) begin
        case (cfg_index)
          CFG_ERROR_RATIO: err_ratio_r   <= cfg_wdata;
          CFG_MIN_SAMPLES: min_samples_r <= cfg_wdata;
          default:         err_ratio_r   <= err_ratio_r;
        endcase
      end
      if (in_xfer) begin
        if (count_r != '1) begin
          count_r <= count_r + 1'b1;
        end
        if (count_r == '0) begin
          mean_r <= in_ch.sample;
          var_r  <= '0;
        end
      end
      if ((state_r == ST_DIVM) && rsp.done) begin
        mean_r <= mean_r + mean_step;
      end
      if ((state_r == ST_DIVV) && rsp.done) begin
        var_r <= var_sum[VAR_W] ? '1 : var_sum[VAR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      sample_r <= in_ch.sample;
      k_r      <= count_r;
      stdev_r  <= '1;
      done_r   <= 1'b0;
    end
    case (state_r)
      ST_DIVM: begin
        if (rsp.done) ad_r <= rsp.x[SAMPLE_W-1:0];
      end
      ST_MULSQ: begin
        if (rsp.done) begin
          tmp_r <= rsp.x[FRAC_BITS +: VAR_W];
          if (sq_sat) term_r <= '1;
        end
      end
      ST_MULN: begin
        if (rsp.done) term_r <= (|rsp.x[PROD_W-1:VAR_W]) ? '1 : rsp.x[VAR_W-1:0];
      end
      ST_DIVQ: begin
        if (rsp.done) tmp_r <= rsp.x[VAR_W-1:0];
      end
      ST_SQRT: begin
        if (rsp.done) stdev_r <= SAMPLE_W'(rsp.y[ROOT_W-1:0]);
      end
      ST_PROD1: p1_r <= mul_p;
      ST_PROD2: p2_r <= mul_p;
      ST_CMP: begin
        done_r <= (count_r >= COUNT_BITS'(min_samples_r)) && (p1_r <= p2_r);
      end
      default: begin
        p1_r <= p1_r;
      end
    endcase
  end

  assign in_ch.ready         = (state_r == ST_IDLE);
  assign out_ch.valid        = (state_r == ST_OUT);
  assign out_ch.mean_out     = mean_r;
  assign out_ch.stdev_out    = stdev_r;
  assign out_ch.sample_count = count_r;
  assign out_ch.done_res     = done_r;

endmodule

[rtl/rmsst_iter.sv]
// Shared bit-serial unit: shift-add multiply, restoring divide and square root.
module rmsst_iter (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rmsst_pkg::iter_req_t  req,
  output rmsst_pkg::iter_rsp_t  rsp
);
  import rmsst_pkg::*;

  iter_op_t           op_r;
  logic               busy_r;
  logic               done_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [PROD_W-1:0]  x_r;
  logic [MUL_B_W-1:0] y_r;
  logic [REM_W-1:0]   rem_r;
  logic [VAR_W-1:0]   b_r;

  logic [REM_W-1:0]   div_sh;
  logic [REM_W-1:0]   div_b;
  logic               div_ge;
  logic [REM_W-1:0]   sq_sh;
  logic [REM_W-1:0]   sq_trial;
  logic               sq_ge;
  logic [PROD_W-1:0]  mul_sum;
  logic [CNT_W-1:0]   last;

  always_comb begin
    div_sh   = {rem_r[REM_W-2:0], x_r[VAR_W-1]};
    div_b    = REM_W'(b_r[DIV_W-1:0]);
    div_ge   = (div_sh >= div_b);
    sq_sh    = {rem_r[REM_W-3:0], x_r[RAD_W-1 -: 2]};
    sq_trial = REM_W'({y_r[ROOT_W-1:0], 2'b01});
    sq_ge    = (sq_sh >= sq_trial);
    mul_sum  = {x_r[PROD_W-2:0], 1'b0} + (y_r[MUL_B_W-1] ? PROD_W'(b_r) : '0);
    case (op_r)
      OP_MUL:  last = CNT_W'(MUL_STEPS - 1);
      OP_DIV:  last = CNT_W'(DIV_STEPS - 1);
      OP_SQRT: last = CNT_W'(ROOT_W - 1);
      default: last = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      op_r   <= OP_MUL;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        op_r   <= req.op;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == last) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      case (req.op)
        OP_MUL: begin
          x_r <= '0;
          b_r <= req.a;
          y_r <= req.b[MUL_B_W-1:0];
        end
        OP_DIV: begin
          x_r <= PROD_W'(req.a);
          b_r <= req.b;
          y_r <= '0;
        end
        OP_SQRT: begin
          x_r <= PROD_W'({req.a, {FRAC_BITS{1'b0}}});
          b_r <= '0;
          y_r <= '0;
        end
        default: begin
          x_r <= '0;
          b_r <= '0;
          y_r <= '0;
        end
      endcase
    end else if (busy_r) begin
      case (op_r)
        OP_MUL: begin
          x_r <= mul_sum;
          y_r <= {y_r[MUL_B_W-2:0], 1'b0};
        end
        OP_DIV: begin
          // Dividend bits leave at the top while quotient bits enter at the bottom.
          x_r   <= {x_r[PROD_W-2:0], div_ge};
          rem_r <= div_ge ? (div_sh - div_b) : div_sh;
        end
        OP_SQRT: begin
          x_r   <= {x_r[PROD_W-3:0], 2'b00};
          rem_r <= sq_ge ? (sq_sh - sq_trial) : sq_sh;
          y_r   <= {y_r[MUL_B_W-2:0], sq_ge};
        end
        default: begin
          x_r <= x_r;
        end
      endcase
    end
  end

  assign rsp.done = done_r;
  assign rsp.x    = x_r;
  assign rsp.y    = y_r;

endmodule

[dv/tb_running_mean_stdev_stop_test.sv]
// Self-checking testbench for the running mean / standard error stop-test block.
`timescale 1ns / 100ps

module tb_running_mean_stdev_stop_test;
  import rmsst_pkg::*;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] mean;
    logic [SAMPLE_W-1:0]        stdev;
    logic [COUNT_BITS-1:0]      count;
    logic                       done;
  } stats_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] smp;
    logic                typed;
    stats_t              want;
  } dir_row_t;

  localparam int     DIR_ROWS   = 20;
  localparam int     PHASES     = 7;
  localparam int     PHASE_LEN  = 200;
  localparam longint SMP_MAX    = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SMP_MIN    = -64'sh0000_8000_0000_0000;
  localparam logic [SAMPLE_W-1:0] SEED_SMP = 48'h0000_1234_8000;

  // The first two rows are the same sample with error ratio at its maximum and no minimum
  // count: the first gives no estimate, the second gives zero spread and meets the target.
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    '{smp: SEED_SMP, typed: 1'b1,
      want: '{mean: SEED_SMP, stdev: '1, count: 32'd1, done: 1'b0}},
    '{smp: SEED_SMP, typed: 1'b1,
      want: '{mean: SEED_SMP, stdev: '0, count: 32'd2, done: 1'b1}},
    '{smp: 48'h7FFF_FFFF_FFFF, typed: 1'b0, want: '0},
    '{smp: 48'h8000_0000_0000, typed: 1'b0, want: '0},
    '{smp: 48'h0000_0000_0000, typed: 1'b0, want: '0},
    '{smp: 48'hFFFF_FFFF_FFFF, typed: 1'b0, want: '0},
    '{smp: 48'h0000_0000_0001, typed: 1'b0, want: '0},
    '{smp: 48'h5555_5555_5555, typed: 1'b0, want: '0},
    '{smp: 48'hAAAA_AAAA_AAAA, typed: 1'b0, want: '0},
    '{smp: 48'h0000_0001_0000, typed: 1'b0, want: '0},
    '{smp: 48'hFFFF_FFFF_0000, typed: 1'b0, want: '0},
    '{smp: 48'h7FFF_FFFF_FFFF, typed: 1'b0, want: '0},
    '{smp: 48'h7FFF_FFFF_FFFF, typed: 1'b0, want: '0},
    '{smp: 48'h8000_0000_0000, typed: 1'b0, want: '0},
    '{smp: 48'h8000_0000_0001, typed: 1'b0, want: '0},
    '{smp: 48'h0000_8000_0000, typed: 1'b0, want: '0},
    '{smp: 48'hFFFF_7FFF_FFFF, typed: 1'b0, want: '0},
    '{smp: 48'h7FFF_0000_0000, typed: 1'b0, want: '0},
    '{smp: 48'h0123_4567_89AB, typed: 1'b0, want: '0},
    '{smp: 48'hFEDC_BA98_7654, typed: 1'b0, want: '0}
  };

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  rmsst_in_if  in_ch ();
  rmsst_out_if out_ch ();

  running_mean_stdev_stop_test DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Predictor copy of the accumulator and its limits.
  logic [COUNT_BITS-1:0] acc_count;
  logic [SAMPLE_W-1:0]   acc_mean;
  logic [VAR_W-1:0]      acc_var;
  logic [CFG_W-1:0]      lim_ratio;
  logic [CFG_W-1:0]      lim_min;

  stats_t pending_stats [$];
  int     mismatches   = 0;
  int     samples_sent = 0;
  int     results_seen = 0;
  int     done_seen    = 0;
  int     settings_run = 0;
  bit     in_quiet     = 1'b0;
  bit     out_quiet    = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #25_000_000;
    $display("Timed out with %0d results still outstanding.", pending_stats.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic stats_t advance_stats(input logic [SAMPLE_W-1:0] smp);
    stats_t       r;
    longint       x, prior, n, d, m;
    logic [63:0]  k, ad, sq, term, v, q, amean;
    logic [127:0] p, rad;
    logic [47:0]  root, cand;
    int           b;
    r = '0;
    r.stdev = '1;
    x = {{16{smp[47]}}, smp};
    k = 64'(acc_count);
    if (k == 0) begin
      acc_mean = smp;
      acc_var = '0;
    end else begin
      prior = {{16{acc_mean[47]}}, acc_mean};
      n = longint'(k) + 1;
      // Signed division truncates toward zero, matching the magnitude division in the design.
      d = (x - prior) / n;
      ad = (d < 0) ? -d : d;
      acc_mean = 48'(prior + d);
      p = 128'(ad) * 128'(ad);
      if (p[127:80] != '0) begin
        term = '1;
      end else begin
        sq = p[79:16];
        p = 128'(sq) * 128'(n);
        term = (p[127:64] != '0) ? '1 : p[63:0];
      end
      v = acc_var - acc_var / k;
      v = (v > ~term) ? '1 : v + term;
      acc_var = v;
      q = v / k;
      rad = {48'd0, q, 16'd0};
      root = '0;
      for (b = 47; b >= 0; b--) begin
        cand = root | (48'd1 << b);
        if (128'(cand) * 128'(cand) <= rad) root = cand;
      end
      r.stdev = root;
    end
    if (acc_count != '1) acc_count = acc_count + 1'b1;
    m = {{16{acc_mean[47]}}, acc_mean};
    amean = (m < 0) ? -m : m;
    r.mean = acc_mean;
    r.count = acc_count;
    r.done = (k != 0) && (acc_count >= 32'(lim_min)) &&
             (64'(r.stdev) * 64'(STOP_FACTOR) <= 64'(lim_ratio) * amean);
    return r;
  endfunction

  function automatic logic [SAMPLE_W-1:0] draw_sample(input longint center, input int spread);
    logic [63:0] bits;
    longint      v;
    bits = {$urandom, $urandom};
    case ($urandom_range(0, 19))
      0:       v = {{16{bits[47]}}, bits[47:0]};
      1:       v = longint'(bits[20:0]) - 64'sd1048576;
      default: v = center + longint'(bits & ((64'd1 << spread) - 1)) - (64'sd1 <<< (spread - 1));
    endcase
    if (v > SMP_MAX) v = SMP_MAX;
    else if (v < SMP_MIN) v = SMP_MIN;
    return v[SAMPLE_W-1:0];
  endfunction

  task automatic push_sample(input logic [SAMPLE_W-1:0] smp, input logic typed,
                             input stats_t want);
    int     gap;
    stats_t pred;
    gap = in_quiet ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.sample <= smp;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    // The predictor always advances so that later rows see the right state.
    pred = advance_stats(smp);
    pending_stats.push_back(typed ? want : pred);
    samples_sent++;
  endtask

  task automatic set_limits(input logic [CFG_W-1:0] ratio, input logic [CFG_W-1:0] minimum);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ERROR_RATIO;
    cfg_wdata <= ratio;
    @(posedge clk);
    cfg_index <= CFG_MIN_SAMPLES;
    cfg_wdata <= minimum;
    @(posedge clk);
    cfg_we    <= 1'b0;
    lim_ratio = ratio;
    lim_min   = minimum;
    settings_run++;
  endtask

  task automatic drain_results();
    while (pending_stats.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin : result_side
    int     stall;
    stats_t got, want;
    out_ch.ready = 1'b0;
    forever begin
      if (results_seen % 30 == 0) out_quiet = ($urandom_range(0, 3) == 0);
      stall = out_quiet ? 0 : $urandom_range(0, 17);
      if (stall == 0) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b0;
        do @(posedge clk); while (out_ch.valid !== 1'b1);
        repeat (stall - 1) @(posedge clk);
        out_ch.ready <= 1'b1;
      end
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      got.mean  = out_ch.mean_out;
      got.stdev = out_ch.stdev_out;
      got.count = out_ch.sample_count;
      got.done  = out_ch.done_res;
      if (pending_stats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Result transfer with nothing outstanding: mean %0d count %0d",
                   $signed(got.mean), got.count);
        end
      end else begin
        want = pending_stats.pop_front();
        if (got.mean !== want.mean || got.stdev !== want.stdev ||
            got.count !== want.count || got.done !== want.done) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Result %0d: expected mean %0d stdev %0d count %0d done %0b",
                     results_seen, $signed(want.mean), want.stdev, want.count, want.done);
            $display("           got      mean %0d stdev %0d count %0d done %0b",
                     $signed(got.mean), got.stdev, got.count, got.done);
          end
        end
      end
      if (got.done === 1'b1) done_seen++;
      results_seen++;
    end
  end

  initial begin : sample_side
    int               p, i;
    int               spread;
    longint           center;
    logic [63:0]      bits;
    logic [CFG_W-1:0] ratio, minimum;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.sample = '0;
    cfg_we       = 1'b0;
    cfg_index    = CFG_ERROR_RATIO;
    cfg_wdata    = '0;
    acc_count    = '0;
    acc_mean     = '0;
    acc_var      = '0;
    lim_ratio    = 16'd655;
    lim_min      = 16'd30;
    center       = 0;
    spread       = 1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_limits(16'hFFFF, 16'd0);
    for (i = 0; i < DIR_ROWS; i++) begin
      push_sample(DIR_TABLE[i].smp, DIR_TABLE[i].typed, DIR_TABLE[i].want);
    end
    in_ch.valid <= 1'b0;

    for (p = 0; p < PHASES; p++) begin
      drain_results();
      case (p)
        0: begin ratio = 16'd655;   minimum = 16'd30;    end
        1: begin ratio = 16'd0;     minimum = 16'd0;     end
        2: begin ratio = 16'hFFFF;  minimum = 16'hFFFF;  end
        3: begin ratio = 16'd0;     minimum = 16'hFFFF;  end
        6: begin ratio = 16'hFFFF;  minimum = 16'd1;     end
        default: begin
          // Put the minimum count just ahead so the threshold is crossed mid-phase.
          ratio   = 16'($urandom_range(0, 65535));
          minimum = 16'(acc_count + $urandom_range(0, 80));
        end
      endcase
      set_limits(ratio, minimum);
      for (i = 0; i < PHASE_LEN; i++) begin
        if (i % 25 == 0) in_quiet = ($urandom_range(0, 3) == 0);
        // Most samples cluster tightly around one level, which lets the mean settle.
        if (i % 100 == 0) begin
          bits = {$urandom, $urandom};
          case ($urandom_range(0, 3))
            0: center = SMP_MAX - longint'(bits[19:0]);
            1: center = SMP_MIN + longint'(bits[19:0]);
            2: begin
              center = longint'(bits[31:0]) << $urandom_range(0, 15);
              if (bits[63]) center = -center;
            end
            default: center = longint'(bits[23:0]) - 64'sd8388608;
          endcase
          spread = $urandom_range(1, 30);
        end
        push_sample(draw_sample(center, spread), 1'b0, '0);
      end
      in_ch.valid <= 1'b0;
    end

    drain_results();
    repeat (400) @(posedge clk);
    $display("Sent %0d samples, %0d from the directed table, under %0d limit settings.",
             samples_sent, DIR_ROWS, settings_run);
    $display("%0d of %0d results met the stop target; final count %0d, final mean %0d.",
             done_seen, results_seen, acc_count, $signed(acc_mean));
    if (mismatches == 0 && pending_stats.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
